[sv/sstf_pkg.sv]
// Shared constants and types for the shortest-seek-first scheduler.
package sstf_pkg;

  localparam int unsigned MAX_REQUESTS = 64;
  localparam int unsigned CYL_W        = 10;
  localparam int unsigned TOTAL_W      = 16;
  localparam int unsigned CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  typedef logic [CYL_W-1:0]   cyl_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  function automatic cyl_t cyl_dist(cyl_t a, cyl_t b);
    return (a >= b) ? cyl_t'(a - b) : cyl_t'(b - a);
  endfunction

endpackage

[sv/shortest_seek_first_scheduler_top.sv]
// Shortest-seek-first head scheduler: request store, scan loop and result registers.
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+-------------------------
//  request | operation_i, cylinder_i                            | start & !busy
//  result  | from/to_cylinder_o, movement_o, total_movement_o,  | result_valid_o, 1 cycle
//          | last_of_run_o, no_requests_o                       |
//
// A start with n pending requests yields n results; each pick scans the request memory
// one entry per cycle, then settles the last compare and emits. An empty start yields a
// single result. The one read port of the request memory sets the scan rate. Reset clears
// pending marks, counts, head and total at once; the receiver cannot stall, so results
// never wait.
module shortest_seek_first_scheduler_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  sstf_pkg::cyl_t        cylinder_i,
  output logic                  result_valid_o,
  output sstf_pkg::cyl_t        from_cylinder_o,
  output sstf_pkg::cyl_t        to_cylinder_o,
  output sstf_pkg::cyl_t        movement_o,
  output sstf_pkg::total_t      total_movement_o,
  output logic                  last_of_run_o,
  output logic                  no_requests_o
);
  import sstf_pkg::*;

  state_e state_q, state_d;

  cyl_t   mem [MAX_REQUESTS];
  cyl_t   rd_data_q;
  logic   rd_vld_q, rd_vld_d;
  idx_t   rd_idx_q;

  logic [MAX_REQUESTS-1:0] pending_q, pending_d;
  cnt_t   loaded_q, loaded_d;
  cnt_t   remaining_q, remaining_d;
  idx_t   scan_idx_q, scan_idx_d;
  cyl_t   head_q, head_d;
  total_t total_q, total_d;

  logic   found_q, found_d;
  idx_t   best_idx_q, best_idx_d;
  cyl_t   best_cyl_q, best_cyl_d;
  cyl_t   best_d_q, best_d_d;

  logic   out_vld_q, out_vld_d;
  cyl_t   out_from_q, out_from_d;
  cyl_t   out_to_q, out_to_d;
  cyl_t   out_move_q, out_move_d;
  total_t out_total_q, out_total_d;
  logic   out_last_q, out_last_d;
  logic   out_none_q, out_none_d;

  logic   accept;
  logic   do_load;
  logic   scan_last;
  cnt_t   last_cnt;
  cyl_t   rd_dist;
  logic   take;
  logic [TOTAL_W:0] total_sum;
  total_t total_sat;

  assign accept    = start && !busy;
  assign do_load   = accept && (operation_i == OP_LOAD) && (loaded_q < cnt_t'(MAX_REQUESTS));
  assign last_cnt  = cnt_t'(loaded_q - cnt_t'(1));
  assign scan_last = (scan_idx_q == last_cnt[IDX_W-1:0]);
  assign rd_dist   = cyl_dist(rd_data_q, head_q);
  assign take      = rd_vld_q && (!found_q || (rd_dist < best_d_q));
  assign total_sum = {1'b0, total_q} + {{(TOTAL_W + 1 - CYL_W){1'b0}}, best_d_q};
  assign total_sat = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_START) && (loaded_q != '0)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        state_d = (remaining_q == cnt_t'(1)) ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pending_d   = pending_q;
    loaded_d    = loaded_q;
    remaining_d = remaining_q;
    scan_idx_d  = scan_idx_q;
    head_d      = head_q;
    total_d     = total_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_cyl_d  = best_cyl_q;
    best_d_d    = best_d_q;
    rd_vld_d    = 1'b0;
    out_vld_d   = 1'b0;
    out_from_d  = out_from_q;
    out_to_d    = out_to_q;
    out_move_d  = out_move_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;
    out_none_d  = out_none_q;

    // compare stage runs in the cycle after the memory read
    if (take) begin
      found_d    = 1'b1;
      best_idx_d = rd_idx_q;
      best_cyl_d = rd_data_q;
      best_d_d   = rd_dist;
    end

    case (state_q)
      ST_IDLE: begin
        if (do_load) begin
          pending_d[loaded_q[IDX_W-1:0]] = 1'b1;
          loaded_d = cnt_t'(loaded_q + cnt_t'(1));
        end
        if (accept && (operation_i == OP_START)) begin
          head_d      = cylinder_i;
          total_d     = '0;
          remaining_d = loaded_q;
          scan_idx_d  = '0;
          found_d     = 1'b0;
          if (loaded_q == '0) begin
            out_vld_d   = 1'b1;
            out_from_d  = cylinder_i;
            out_to_d    = cylinder_i;
            out_move_d  = '0;
            out_total_d = '0;
            out_last_d  = 1'b1;
            out_none_d  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_d   = pending_q[scan_idx_q];
        scan_idx_d = idx_t'(scan_idx_q + idx_t'(1));
      end
      ST_DRAIN: ;
      ST_EMIT: begin
        out_vld_d   = 1'b1;
        out_from_d  = head_q;
        out_to_d    = best_cyl_q;
        out_move_d  = best_d_q;
        out_total_d = total_sat;
        out_last_d  = (remaining_q == cnt_t'(1));
        out_none_d  = 1'b0;
        total_d     = total_sat;
        head_d      = best_cyl_q;
        remaining_d = cnt_t'(remaining_q - cnt_t'(1));
        pending_d[best_idx_q] = 1'b0;
        scan_idx_d  = '0;
        found_d     = 1'b0;
        if (remaining_q == cnt_t'(1)) begin
          pending_d = '0;
          loaded_d  = '0;
        end
      end
      default: ;
    endcase
  end

  // Request memory: writes only while idle; reads every cycle, used only while scanning
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem[loaded_q[IDX_W-1:0]] <= cylinder_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[scan_idx_q];
    rd_idx_q  <= scan_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= '0;
      loaded_q    <= '0;
      remaining_q <= '0;
      scan_idx_q  <= '0;
      head_q      <= '0;
      total_q     <= '0;
      found_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      loaded_q    <= loaded_d;
      remaining_q <= remaining_d;
      scan_idx_q  <= scan_idx_d;
      head_q      <= head_d;
      total_q     <= total_d;
      found_q     <= found_d;
      rd_vld_q    <= rd_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_cyl_q  <= best_cyl_d;
    best_d_q    <= best_d_d;
    out_from_q  <= out_from_d;
    out_to_q    <= out_to_d;
    out_move_q  <= out_move_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
    out_none_q  <= out_none_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = out_vld_q;
  assign from_cylinder_o  = out_from_q;
  assign to_cylinder_o    = out_to_q;
  assign movement_o       = out_move_q;
  assign total_movement_o = out_total_q;
  assign last_of_run_o    = out_last_q;
  assign no_requests_o    = out_none_q;

endmodule

[sv/sstf_checker.sv]
// Port-level checks for the shortest-seek-first scheduler, bound to the top level.
module sstf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  operation_i,
  input logic                  result_valid_o,
  input sstf_pkg::cyl_t        from_cylinder_o,
  input sstf_pkg::cyl_t        to_cylinder_o,
  input sstf_pkg::cyl_t        movement_o,
  input sstf_pkg::total_t      total_movement_o,
  input logic                  last_of_run_o,
  input logic                  no_requests_o
);
  import sstf_pkg::*;

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OP_LOAD) |=> !result_valid_o)
    else $error("result after a load request");

  // a start either begins a run or answers at once
  a_start_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OP_START) |=> (busy || result_valid_o))
    else $error("start request had no effect");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && no_requests_o) |->
      (last_of_run_o && movement_o == '0 && total_movement_o == '0 &&
       from_cylinder_o == to_cylinder_o))
    else $error("malformed empty-start result");

  // mid-run results keep the block busy
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_run_o) |-> busy)
    else $error("run stopped before its last result");

  a_total_covers_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (total_movement_o >= TOTAL_W'(movement_o)))
    else $error("running total below step movement");

endmodule

bind shortest_seek_first_scheduler_top sstf_checker u_sstf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .operation_i      (operation_i),
  .result_valid_o   (result_valid_o),
  .from_cylinder_o  (from_cylinder_o),
  .to_cylinder_o    (to_cylinder_o),
  .movement_o       (movement_o),
  .total_movement_o (total_movement_o),
  .last_of_run_o    (last_of_run_o),
  .no_requests_o    (no_requests_o)
);

[verif/tb_top.sv]
// Self-checking testbench for the shortest-seek-first scheduler: directed table, then random runs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sstf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 88;

  typedef struct packed {
    cyl_t   from_cyl;
    cyl_t   to_cyl;
    cyl_t   step_len;
    total_t total;
    logic   last;
    logic   none;
  } move_t;

  typedef struct packed {
    logic  op;
    cyl_t  cyl;
    logic  typed;
    move_t want;
  } step_t;

  localparam move_t NO_MOVE = '0;
  localparam int unsigned PLAN_LEN = 22;

  // Rows with typed set carry their single expected result; the rest go through the predictor.
  step_t plan [0:PLAN_LEN-1] = '{
    '{OP_START, 10'd0,    1'b1, '{10'd0,    10'd0,    10'd0,    16'd0,    1'b1, 1'b1}},
    '{OP_START, 10'd1023, 1'b1, '{10'd1023, 10'd1023, 10'd0,    16'd0,    1'b1, 1'b1}},
    '{OP_LOAD,  10'd1023, 1'b0, NO_MOVE},
    '{OP_START, 10'd0,    1'b1, '{10'd0,    10'd1023, 10'd1023, 16'd1023, 1'b1, 1'b0}},
    '{OP_LOAD,  10'd0,    1'b0, NO_MOVE},
    '{OP_START, 10'd1023, 1'b1, '{10'd1023, 10'd0,    10'd1023, 16'd1023, 1'b1, 1'b0}},
    // equal distance on both sides: lower index wins
    '{OP_LOAD,  10'd510,  1'b0, NO_MOVE},
    '{OP_LOAD,  10'd490,  1'b0, NO_MOVE},
    '{OP_START, 10'd500,  1'b0, NO_MOVE},
    // duplicates sitting under the head
    '{OP_LOAD,  10'd300,  1'b0, NO_MOVE},
    '{OP_LOAD,  10'd300,  1'b0, NO_MOVE},
    '{OP_START, 10'd300,  1'b0, NO_MOVE},
    // cylinders past 999 are plain values
    '{OP_LOAD,  10'd1000, 1'b0, NO_MOVE},
    '{OP_LOAD,  10'd999,  1'b0, NO_MOVE},
    '{OP_LOAD,  10'd1023, 1'b0, NO_MOVE},
    '{OP_START, 10'd1010, 1'b0, NO_MOVE},
    '{OP_LOAD,  10'd0,    1'b0, NO_MOVE},
    '{OP_LOAD,  10'd1023, 1'b0, NO_MOVE},
    '{OP_START, 10'd1023, 1'b0, NO_MOVE},
    // store must be empty again after a run
    '{OP_START, 10'd5,    1'b1, '{10'd5,    10'd5,    10'd0,    16'd0,    1'b1, 1'b1}},
    '{OP_LOAD,  10'd1,    1'b0, NO_MOVE},
    '{OP_START, 10'd1022, 1'b0, NO_MOVE}
  };

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start;
  logic   busy;
  logic   operation_i;
  cyl_t   cylinder_i;
  logic   result_valid_o;
  cyl_t   from_cylinder_o;
  cyl_t   to_cylinder_o;
  cyl_t   movement_o;
  total_t total_movement_o;
  logic   last_of_run_o;
  logic   no_requests_o;

  // Predictor state
  cyl_t        req_cyl [MAX_REQUESTS];
  logic        req_pending [MAX_REQUESTS];
  int unsigned req_count;
  cyl_t        head_pos;
  int unsigned seek_total;

  move_t       due_moves [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned accepted_items;
  bit          quiet_burst;

  shortest_seek_first_scheduler_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .cylinder_i       (cylinder_i),
    .result_valid_o   (result_valid_o),
    .from_cylinder_o  (from_cylinder_o),
    .to_cylinder_o    (to_cylinder_o),
    .movement_o       (movement_o),
    .total_movement_o (total_movement_o),
    .last_of_run_o    (last_of_run_o),
    .no_requests_o    (no_requests_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Applies one request to the predicted state and queues the moves it causes.
  function automatic void predict_moves(input logic op, input cyl_t cyl);
    int unsigned best;
    int unsigned best_d;
    int unsigned d;
    int unsigned left;
    bit          found;
    move_t       m;
    if (op == OP_LOAD) begin
      if (req_count < MAX_REQUESTS) begin
        req_cyl[req_count] = cyl;
        req_pending[req_count] = 1'b1;
        req_count++;
      end
      return;
    end
    head_pos = cyl;
    seek_total = 0;
    if (req_count == 0) begin
      m = '{head_pos, head_pos, '0, '0, 1'b1, 1'b1};
      due_moves.push_back(m);
      return;
    end
    left = req_count;
    while (left > 0) begin
      found = 1'b0;
      best = 0;
      best_d = 0;
      for (int i = 0; i < req_count; i++) begin
        if (req_pending[i]) begin
          d = (req_cyl[i] >= head_pos) ? req_cyl[i] - head_pos : head_pos - req_cyl[i];
          if (!found || d < best_d) begin
            best = i;
            best_d = d;
            found = 1'b1;
          end
        end
      end
      if (!found) break;
      seek_total += best_d;
      if (seek_total > 16'hFFFF) seek_total = 16'hFFFF;
      left--;
      m.from_cyl = head_pos;
      m.to_cyl = req_cyl[best];
      m.step_len = cyl_t'(best_d);
      m.total = total_t'(seek_total);
      m.last = (left == 0);
      m.none = 1'b0;
      due_moves.push_back(m);
      req_pending[best] = 1'b0;
      head_pos = req_cyl[best];
    end
    for (int i = 0; i < MAX_REQUESTS; i++) req_pending[i] = 1'b0;
    req_count = 0;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic op, input cyl_t cyl, input logic typed,
                              input move_t want);
    int unsigned gap;
    int unsigned n0;
    gap = quiet_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      operation_i <= 1'($urandom);
      cylinder_i <= cyl_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    cylinder_i <= cyl;
    do @(posedge clk_i); while (busy);
    if (op == OP_START || req_count < MAX_REQUESTS) accepted_items++;
    n0 = due_moves.size();
    predict_moves(op, cyl);
    if (typed) begin
      while (due_moves.size() > n0) void'(due_moves.pop_back());
      due_moves.push_back(want);
    end
    @(negedge clk_i);
  endtask

  function automatic cyl_t pick_cyl();
    cyl_t c;
    case ($urandom_range(0, 3))
      0, 1: c = cyl_t'($urandom_range(0, 1023));
      2: c = cyl_t'(480 + 8 * $urandom_range(0, 8));  // grid around the middle breeds ties
      default: begin
        case ($urandom_range(0, 5))
          0: c = 10'd0;
          1: c = 10'd1;
          2: c = 10'd998;
          3: c = 10'd999;
          4: c = 10'd1000;
          default: c = 10'd1023;
        endcase
      end
    endcase
    return c;
  endfunction

  always @(posedge clk_i) begin
    move_t want;
    if (rst_ni && result_valid_o) begin
      if (due_moves.size() == 0) begin
        flag_error($sformatf("unexpected result %0d -> %0d", from_cylinder_o, to_cylinder_o));
      end else begin
        want = due_moves.pop_front();
        if (from_cylinder_o !== want.from_cyl)
          flag_error($sformatf("from_cylinder %0d, want %0d", from_cylinder_o, want.from_cyl));
        if (to_cylinder_o !== want.to_cyl)
          flag_error($sformatf("to_cylinder %0d, want %0d", to_cylinder_o, want.to_cyl));
        if (movement_o !== want.step_len)
          flag_error($sformatf("movement %0d, want %0d", movement_o, want.step_len));
        if (total_movement_o !== want.total)
          flag_error($sformatf("total_movement %0d, want %0d", total_movement_o, want.total));
        if (last_of_run_o !== want.last)
          flag_error($sformatf("last_of_run %0b, want %0b", last_of_run_o, want.last));
        if (no_requests_o !== want.none)
          flag_error($sformatf("no_requests %0b, want %0b", no_requests_o, want.none));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned nloads;
    int unsigned seq_no;
    int unsigned full_at;
    bit          with_start;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = 1'b0;
    cylinder_i = '0;
    error_count = 0;
    cycle_count = 0;
    accepted_items = 0;
    quiet_burst = 1'b0;
    req_count = 0;
    head_pos = '0;
    seek_total = 0;
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      req_cyl[i] = '0;
      req_pending[i] = 1'b0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < PLAN_LEN; r++) begin
      quiet_burst = (r >= 12 && r < 16);
      send_request(plan[r].op, plan[r].cyl, plan[r].typed, plan[r].want);
    end

    // Mostly loads followed by a start; now and then a lone start, or loads left
    // hanging for the next run. One run fills the store and may overflow it.
    accepted_items = 0;
    seq_no = 0;
    full_at = $urandom_range(1, 4);
    while (accepted_items < RANDOM_ITEMS) begin
      quiet_burst = ($urandom_range(0, 3) == 0);
      with_start = 1'b1;
      if (seq_no == full_at) begin
        nloads = $urandom_range(MAX_REQUESTS, MAX_REQUESTS + 4);
      end else begin
        case ($urandom_range(0, 9))
          0: nloads = 0;
          1: begin
            nloads = $urandom_range(1, 3);
            with_start = 1'b0;
          end
          default: nloads = $urandom_range(1, 8);
        endcase
      end
      repeat (nloads) send_request(OP_LOAD, pick_cyl(), 1'b0, NO_MOVE);
      if (with_start) send_request(OP_START, pick_cyl(), 1'b0, NO_MOVE);
      seq_no++;
    end
    start <= 1'b0;

    while (due_moves.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
